// ===== src/mlqs_pkg.sv =====
// Shared types and constants for the multilevel queue scheduler.
// No dependencies; every other file of the block imports this package.
package mlqs_pkg;

  // default sizes, handed to the top level as parameter defaults
  localparam int NumLevelsDef  = 10;
  localparam int LevelDepthDef = 16;

  // fixed field widths
  localparam int IdW       = 8;
  localparam int JobLevelW = 5;
  localparam int QuantW    = 8;
  localparam int FcfsW     = 4;
  // level code carried between modules, wide enough for the largest level count
  localparam int LvlFieldW = 4;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [FcfsW-1:0]  FcfsLastReset     = 4'd4;
  localparam logic [QuantW-1:0] QuantumReloadReset = 8'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FCFS_LAST = 1'b0,
    CFG_QUANTUM   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_ENQUEUE  = 1'b0,
    ACT_SCHEDULE = 1'b1
  } act_e;

  // one push and one pop per beat, applied to the level queues
  typedef struct packed {
    logic                 pop;
    logic [LvlFieldW-1:0] pop_lvl;
    logic                 push;
    logic [LvlFieldW-1:0] push_lvl;
    logic [IdW-1:0]       push_id;
  } q_op_t;

endpackage

// ===== src/mlqs_in_if.sv =====
// Input channel of the scheduler: enqueue or schedule beats.
// Depends on mlqs_pkg for field widths.
interface mlqs_in_if import mlqs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [IdW-1:0]              job_id;
  logic signed [JobLevelW-1:0] job_level;
  logic [QuantW-1:0]           quantum_left;

  modport source (output valid, action, job_id, job_level, quantum_left, input ready);
  modport sink   (input valid, action, job_id, job_level, quantum_left, output ready);
endinterface

// ===== src/mlqs_out_if.sv =====
// Result channel of the scheduler: one decision beat per input beat.
// Depends on mlqs_pkg for field widths.
interface mlqs_out_if import mlqs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [IdW-1:0]              next_id;
  logic signed [JobLevelW-1:0] next_level;
  logic                        next_is_idle;
  logic                        next_is_fresh;
  logic                        current_requeued;
  logic                        current_time_cleared;
  logic [QuantW-1:0]           new_quantum;
  logic                        overflow;

  modport source (output valid, next_id, next_level, next_is_idle, next_is_fresh,
                  current_requeued, current_time_cleared, new_quantum, overflow,
                  input ready);
  modport sink   (input valid, next_id, next_level, next_is_idle, next_is_fresh,
                  current_requeued, current_time_cleared, new_quantum, overflow,
                  output ready);
endinterface

// ===== src/mlqs_queues.sv =====
// Per-level FIFO queues of job ids: counts, head and tail pointers and the id store.
// Depends on mlqs_pkg (q_op_t, widths).
module mlqs_queues import mlqs_pkg::*; #(
  parameter int NUM_LEVELS  = NumLevelsDef,
  parameter int LEVEL_DEPTH = LevelDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  q_op_t                 op_i,
  output logic [NUM_LEVELS-1:0] nonempty_o,
  output logic                  push_drop_o,
  output logic [IdW-1:0]        pop_data_o
);

  localparam int LvlW = $clog2(NUM_LEVELS);
  localparam int PtrW = $clog2(LEVEL_DEPTH);
  localparam int CntW = $clog2(LEVEL_DEPTH + 1);

  logic [CntW-1:0] count_q [NUM_LEVELS];
  logic [CntW-1:0] count_d [NUM_LEVELS];
  logic [PtrW-1:0] head_q  [NUM_LEVELS];
  logic [PtrW-1:0] head_d  [NUM_LEVELS];
  logic [PtrW-1:0] tail_q  [NUM_LEVELS];
  logic [PtrW-1:0] tail_d  [NUM_LEVELS];

  logic [IdW-1:0]  mem_q [NUM_LEVELS][LEVEL_DEPTH];
  logic [IdW-1:0]  rd_q;

  logic [LvlW-1:0] pop_lvl;
  logic [LvlW-1:0] push_lvl;
  logic            push_full;
  logic            push_ok;

  assign pop_lvl  = op_i.pop_lvl[LvlW-1:0];
  assign push_lvl = op_i.push_lvl[LvlW-1:0];

  // a full queue still takes a push when the same beat pops it first
  assign push_full   = (count_q[push_lvl] == CntW'(LEVEL_DEPTH)) &&
                       !(op_i.pop && (pop_lvl == push_lvl));
  assign push_ok     = op_i.push && !push_full;
  assign push_drop_o = op_i.push && push_full;
  assign pop_data_o  = rd_q;

  // per-level pointer and count update
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      count_d[l] = count_q[l];
      head_d[l]  = head_q[l];
      tail_d[l]  = tail_q[l];
      nonempty_o[l] = (count_q[l] != '0);
      if (op_i.pop && (pop_lvl == LvlW'(l))) begin
        head_d[l]  = (head_q[l] == PtrW'(LEVEL_DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
        count_d[l] = count_d[l] - 1'b1;
      end
      if (push_ok && (push_lvl == LvlW'(l))) begin
        tail_d[l]  = (tail_q[l] == PtrW'(LEVEL_DEPTH - 1)) ? '0 : tail_q[l] + 1'b1;
        count_d[l] = count_d[l] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        count_q[l] <= '0;
        head_q[l]  <= '0;
        tail_q[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        count_q[l] <= count_d[l];
        head_q[l]  <= head_d[l];
        tail_q[l]  <= tail_d[l];
      end
    end
  end

  // id store: one write at the tail, one registered read at the head
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[push_lvl][tail_q[push_lvl]] <= op_i.push_id;
    end
    if (op_i.pop) begin
      rd_q <= mem_q[pop_lvl][head_q[pop_lvl]];
    end
  end

  // checks
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.pop |-> nonempty_o[pop_lvl])
    else $error("pop from an empty level queue");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_drop_o |-> (count_q[push_lvl] == CntW'(LEVEL_DEPTH)))
    else $error("push dropped while queue not full");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !(op_i.pop && (pop_lvl == push_lvl)))
    |=> (count_q[$past(push_lvl)] == $past(count_q[push_lvl]) + 1'b1))
    else $error("push did not raise the level count");

endmodule

// ===== src/multilevel_queue_scheduler.sv =====
// Multilevel queue scheduler top level: input stage, decision logic, result register.
// Depends on mlqs_pkg, mlqs_in_if, mlqs_out_if and mlqs_queues.
//
//   channel   dir  handshake            payload
//   item_i    in   valid/ready          action, job_id, job_level, quantum_left
//   result_o  out  valid/ready          next_id .. overflow, one beat per input beat
//   cfg       in   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// One beat per cycle unless the result stalls; each beat is registered on input.
// The decision (priority encode over the non-empty flags, one pop, one push) sits
// between the input register and the result register; the popped id comes from
// the registered read of the id store. A stalled result holds both stages, and
// input ready then drops. Reset empties every queue at once; no clearing pass.
module multilevel_queue_scheduler import mlqs_pkg::*; #(
  parameter int NUM_LEVELS  = NumLevelsDef,
  parameter int LEVEL_DEPTH = LevelDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mlqs_in_if.sink             item_i,
  mlqs_out_if.source          result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // configuration registers
  logic [FcfsW-1:0]  fcfs_q;
  logic [QuantW-1:0] quant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcfs_q  <= FcfsLastReset;
      quant_q <= QuantumReloadReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FCFS_LAST: fcfs_q  <= cfg_wdata_i[FcfsW-1:0];
        CFG_QUANTUM:   quant_q <= cfg_wdata_i[QuantW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                        s1_v_q;
  act_e                        s1_act_q;
  logic [IdW-1:0]              s1_id_q;
  logic signed [JobLevelW-1:0] s1_lvl_q;
  logic [QuantW-1:0]           s1_qleft_q;
  logic                        adv;
  logic                        in_take;

  // result stage
  logic                        ov_q;
  logic [IdW-1:0]              nid_q;
  logic signed [JobLevelW-1:0] nlev_q;
  logic                        idle_q, fresh_q, req_q, clr_q, ovf_q, sel_mem_q;
  logic [QuantW-1:0]           nq_q;

  assign adv          = s1_v_q && (!ov_q || result_o.ready);
  assign item_i.ready = !s1_v_q || adv;
  assign in_take      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_q <= 1'b1;
      end else if (adv) begin
        s1_v_q <= 1'b0;
      end
      if (adv) begin
        ov_q <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_act_q   <= act_e'(item_i.action);
      s1_id_q    <= item_i.job_id;
      s1_lvl_q   <= item_i.job_level;
      s1_qleft_q <= item_i.quantum_left;
    end
  end

  // queue storage
  q_op_t                 op;
  logic [NUM_LEVELS-1:0] nonempty;
  logic                  push_drop;
  logic [IdW-1:0]        pop_data;

  mlqs_queues #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_queues (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .nonempty_o  (nonempty),
    .push_drop_o (push_drop),
    .pop_data_o  (pop_data)
  );

  // highest non-empty level
  logic [LvlFieldW-1:0] top;
  logic                 any_ready;

  always_comb begin
    top = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        top = LvlFieldW'(i);
      end
    end
  end

  assign any_ready = |nonempty;

  // running level: negative is the idle job, too large clamps to the lowest level
  logic                 lvl_neg;
  logic                 lvl_big;
  logic [LvlFieldW-1:0] cur;

  assign lvl_neg = s1_lvl_q[JobLevelW-1];
  assign lvl_big = !lvl_neg && ({1'b0, s1_lvl_q} >= (JobLevelW + 1)'(NUM_LEVELS));
  assign cur     = lvl_big ? LvlFieldW'(NUM_LEVELS - 1) : s1_lvl_q[LvlFieldW-1:0];

  // decision
  logic [IdW-1:0]              r_nid;
  logic signed [JobLevelW-1:0] r_lvl;
  logic                        r_idle, r_fresh, r_req, r_clr, r_sel_mem;
  logic [QuantW-1:0]           r_nq;

  always_comb begin
    op        = '0;
    op.push_id = s1_id_q;
    r_nid     = '0;
    r_lvl     = '0;
    r_idle    = 1'b0;
    r_fresh   = 1'b0;
    r_req     = 1'b0;
    r_clr     = 1'b0;
    r_sel_mem = 1'b0;
    r_nq      = '0;
    if (s1_act_q == ACT_ENQUEUE) begin
      if (!lvl_neg && !lvl_big) begin
        op.push     = 1'b1;
        op.push_lvl = s1_lvl_q[LvlFieldW-1:0];
      end
    end else if (lvl_neg) begin
      if (any_ready) begin
        op.pop     = 1'b1;
        op.pop_lvl = top;
        r_lvl      = JobLevelW'(top);
        r_fresh    = 1'b1;
        r_sel_mem  = 1'b1;
      end else begin
        r_idle = 1'b1;
        r_lvl  = '1;
      end
    end else if (any_ready && (cur > top)) begin
      // preemption by a higher level
      op.pop      = 1'b1;
      op.pop_lvl  = top;
      op.push     = 1'b1;
      op.push_lvl = cur;
      r_lvl       = JobLevelW'(top);
      r_fresh     = 1'b1;
      r_sel_mem   = 1'b1;
      r_req       = 1'b1;
      r_nq        = quant_q;
    end else if ((cur <= fcfs_q) || (s1_qleft_q != '0)) begin
      r_nid = s1_id_q;
      r_lvl = JobLevelW'(cur);
    end else begin
      // quantum expired on a round robin level
      op.push     = 1'b1;
      op.push_lvl = cur;
      r_req       = 1'b1;
      r_nq        = quant_q;
      if (any_ready) begin
        op.pop     = 1'b1;
        op.pop_lvl = top;
        r_lvl      = JobLevelW'(top);
        r_fresh    = 1'b1;
        r_sel_mem  = 1'b1;
      end else begin
        r_idle = 1'b1;
        r_lvl  = '1;
        r_clr  = 1'b1;
      end
    end
    op.pop  = op.pop && adv;
    op.push = op.push && adv;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nid_q     <= r_nid;
      nlev_q    <= r_lvl;
      idle_q    <= r_idle;
      fresh_q   <= r_fresh;
      req_q     <= r_req;
      clr_q     <= r_clr;
      nq_q      <= r_nq;
      ovf_q     <= push_drop;
      sel_mem_q <= r_sel_mem;
    end
  end

  assign result_o.valid                = ov_q;
  assign result_o.next_id              = sel_mem_q ? pop_data : nid_q;
  assign result_o.next_level           = nlev_q;
  assign result_o.next_is_idle         = idle_q;
  assign result_o.next_is_fresh        = fresh_q;
  assign result_o.current_requeued     = req_q;
  assign result_o.current_time_cleared = clr_q;
  assign result_o.new_quantum          = nq_q;
  assign result_o.overflow             = ovf_q;

  // checks
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && idle_q) |-> ((nlev_q == '1) && !fresh_q && !sel_mem_q))
    else $error("idle result with a dequeued job or a real level");

  a_cleared_requeue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && clr_q) |-> (req_q && idle_q))
    else $error("time cleared without requeue to idle");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> ov_q)
    else $error("advanced beat missing from the result register");

endmodule
